// ===== hdl/iiea_pkg.sv =====
package iiea_pkg;

    // list words
    typedef logic signed [31:0] word_t;

    // widest fill count over the supported capacity range (up to 1024 entries)
    localparam int CNT_MAX_W = 11;

    // command codes
    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_ERASE  = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_WRITE  = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // per-cycle operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN
    } op_t;

    // cell control: operation, target position and shift limit
    typedef struct packed {
        op_t                  op;
        logic [CNT_MAX_W-1:0] tgt;
        logic [CNT_MAX_W-1:0] lim;
    } cell_ctrl_t;

endpackage

// ===== hdl/indexed_insert_erase_array_unit.sv =====
// a command beat passes through the pending stage and then the result register
// throughput: one command per cycle while out_stall is low; every entry cell shifts at
// the same edge and one readout select serves each result
// reset: fill count and both beat-valid flags clear; entry contents stay
// undefined until written
module indexed_insert_erase_array_unit
    import iiea_pkg::*;
#(
    parameter  int CAPACITY = 16,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       cmd,
    input  logic [3:0]       index,
    input  word_t            element,
    output logic             out_valid,
    input  logic             out_stall,
    output word_t            read_value,
    output logic [1:0]       status,
    output logic [CNT_W-1:0] fill_count,
    output logic             empty_flag,
    output word_t            front_value,
    output word_t            back_value
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // list state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    word_t            cells [CAPACITY];
    cell_ctrl_t       ctrl;

    // pending stage between cell update and result register
    logic             p_valid_reg;
    logic [1:0]       p_status_reg;
    logic             p_is_read_reg;
    logic             p_rd_ok_reg;
    logic [CNT_W-1:0] p_addr_reg;
    logic [CNT_W-1:0] p_cnt_reg;

    // result register
    logic             out_valid_reg;
    word_t            out_rd_reg;
    logic [1:0]       out_status_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    word_t            out_front_reg;
    word_t            out_back_reg;
    word_t            back_reg;

    logic             out_free;
    logic             p_move;
    logic             acc;
    logic             in_range;
    logic             full;
    logic [CNT_MAX_W-1:0] idx_x;
    logic [CNT_MAX_W-1:0] cnt_x;
    logic [1:0]       st_now;
    logic             rd_ok_now;
    word_t            sel_data;
    word_t            back_now;

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign p_move   = p_valid_reg && out_free;
    assign in_stall = p_valid_reg && !out_free;
    assign acc      = in_valid && !in_stall;

    // command decode
    assign idx_x    = CNT_MAX_W'(index);
    assign cnt_x    = CNT_MAX_W'(count_reg);
    assign in_range = idx_x < cnt_x;
    assign full     = count_reg == FULL_CNT;

    always_comb
    begin
        st_now     = ST_DONE;
        rd_ok_now  = 1'b0;
        count_next = count_reg;
        ctrl.op    = OP_NONE;
        ctrl.tgt   = idx_x;
        ctrl.lim   = cnt_x;
        unique case (cmd)
            CMD_APPEND:
            begin
                if (full)
                begin
                    st_now = ST_FULL;
                end
                else
                begin
                    ctrl.op    = OP_LOAD;
                    ctrl.tgt   = cnt_x;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (!in_range)
                begin
                    st_now = ST_RANGE;
                end
                else if (full)
                begin
                    st_now = ST_FULL;
                end
                else
                begin
                    ctrl.op    = OP_SHIFT_UP;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_ERASE:
            begin
                if (!in_range)
                begin
                    st_now = ST_RANGE;
                end
                else
                begin
                    ctrl.op    = OP_SHIFT_DOWN;
                    ctrl.lim   = cnt_x - CNT_MAX_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (!in_range)
                begin
                    st_now = ST_RANGE;
                end
                else
                begin
                    rd_ok_now = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                if (!in_range)
                begin
                    st_now = ST_RANGE;
                end
                else
                begin
                    ctrl.op = OP_LOAD;
                end
            end
            default:
            begin
                st_now = ST_DONE;
            end
        endcase
        if (!acc)
        begin
            ctrl.op    = OP_NONE;
            count_next = count_reg;
        end
    end

    // row of entry cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        word_t left_w;
        word_t right_w;
        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cells[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cells[g+1];
        end
        iiea_cell #(
            .POS (g)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .elem  (element),
            .left  (left_w),
            .right (right_w),
            .value (cells[g])
        );
    end

    // readout select: read index for reads, last entry otherwise
    iiea_sel #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_sel (
        .cells (cells),
        .addr  (p_addr_reg),
        .data  (sel_data)
    );

    assign back_now = p_is_read_reg ? back_reg : sel_data;

    // fill count, pending flag and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (acc)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_move)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pending payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p_status_reg  <= st_now;
            p_is_read_reg <= (cmd == CMD_READ);
            p_rd_ok_reg   <= rd_ok_now;
            p_cnt_reg     <= count_next;
            if (cmd == CMD_READ)
            begin
                p_addr_reg <= idx_x[CNT_W-1:0];
            end
            else
            begin
                p_addr_reg <= count_next - CNT_W'(1);
            end
        end
    end

    // result payload and tracked back entry
    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            out_rd_reg     <= p_rd_ok_reg ? sel_data : '0;
            out_status_reg <= p_status_reg;
            out_cnt_reg    <= p_cnt_reg;
            out_front_reg  <= (p_cnt_reg == '0) ? '0 : cells[0];
            out_back_reg   <= (p_cnt_reg == '0) ? '0 : back_now;
            back_reg       <= back_now;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_rd_reg;
    assign status      = out_status_reg;
    assign fill_count  = out_cnt_reg;
    assign empty_flag  = (out_cnt_reg == '0);
    assign front_value = out_front_reg;
    assign back_value  = out_back_reg;

endmodule

// ===== hdl/iiea_cell.sv =====
module iiea_cell
    import iiea_pkg::*;
#(
    parameter int POS = 0
)
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  word_t      elem,
    input  word_t      left,
    input  word_t      right,
    output word_t      value
);

    localparam logic [CNT_MAX_W-1:0] POS_V = CNT_MAX_W'(POS);

    word_t value_reg;
    word_t value_next;

    // pick own value, new element or a neighbor
    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            OP_LOAD:
            begin
                if (POS_V == ctrl.tgt)
                begin
                    value_next = elem;
                end
            end
            OP_SHIFT_UP:
            begin
                if (POS_V == ctrl.tgt)
                begin
                    value_next = elem;
                end
                else if ((POS_V > ctrl.tgt) && (POS_V <= ctrl.lim))
                begin
                    value_next = left;
                end
            end
            OP_SHIFT_DOWN:
            begin
                if ((POS_V >= ctrl.tgt) && (POS_V < ctrl.lim))
                begin
                    value_next = right;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== hdl/iiea_sel.sv =====
module iiea_sel
    import iiea_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
)
(
    input  word_t              cells [CAPACITY],
    input  logic [CNT_W-1:0]   addr,
    output word_t              data
);

    word_t acc;

    // and-or select of the addressed cell
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (addr == CNT_W'(i))
            begin
                acc = acc | cells[i];
            end
        end
    end

    assign data = acc;

endmodule
